// File: design/arcpr_pkg.sv
package arcpr_pkg;

	localparam int MAX_FRAMES_DEF = 64;
	localparam int PAGE_BITS_DEF = 20;
	localparam int CFG_W = 7;
	localparam int FRAME_OUT_W = 6;
	localparam int OUTC_W = 3;
	localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 7'd64;

	typedef enum logic [1:0] {
		LIST_T1,
		LIST_T2,
		LIST_B1,
		LIST_B2
	} list_t;

	typedef enum logic [OUTC_W-1:0] {
		OUTC_MISS,
		OUTC_HIT_T1,
		OUTC_HIT_T2,
		OUTC_GHOST_B1,
		OUTC_GHOST_B2
	} outcome_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_REMOVE,
		OP_PUSH
	} op_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DIV,
		ST_DECIDE,
		ST_UPDATE,
		ST_DONE
	} state_t;

endpackage

// File: design/arcpr_dir.sv
module arcpr_dir #(
	parameter int DEPTH = 128,
	parameter int W = 36
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [W-1:0]             rd_data,
	output logic                     rd_valid,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [W-1:0]             wr_data,
	input  logic                     wr_valid
);

	logic [W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= wr_valid;
			end
			if (rd_en) begin
				rd_valid <= valid_q[rd_addr];
			end
		end
	end

endmodule

// File: design/arcpr_div.sv
module arcpr_div #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);

	localparam int CNTW = $clog2(W + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [W-1:0]    rem_q;
	logic [W-1:0]    quo_q;
	logic [W:0]      rem_sh;
	logic [W:0]      diff;
	logic            ge;

	assign rem_sh = {rem_q, quo_q[W-1]};
	assign ge = rem_sh >= {1'b0, divisor};
	assign diff = rem_sh - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNTW'(W);
				rem_q <= '0;
				quo_q <= dividend;
			end else if (busy_q) begin
				rem_q <= ge ? diff[W-1:0] : rem_sh[W-1:0];
				quo_q <= {quo_q[W-2:0], ge};
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// File: design/arc_page_replacement_core.sv
// Each item takes two full sweeps of the directory memory (one read and one write
// port): one to search and one to rewrite ranks, plus a pass of the serial divider
// on a ghost hit. One item is processed at a time, so the next item is accepted in
// the same cycle as the result appears at the earliest.
// Reset clears the directory valid bits, list counts, target and free frame count
// at once, and sets the capacity register to 64; no clearing pass is needed.
module arc_page_replacement_core import arcpr_pkg::*; #(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [PAGE_BITS-1:0]   page_id,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [OUTC_W-1:0]      outcome,
	output logic                   evicted,
	output logic [PAGE_BITS-1:0]   victim_page,
	output logic [FRAME_OUT_W-1:0] victim_frame,
	output logic [FRAME_OUT_W-1:0] page_frame
);

	localparam int DEPTH = 2 * MAX_FRAMES;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 2;
	localparam int NW = $clog2(MAX_FRAMES + 1);
	localparam int FW = ($clog2(MAX_FRAMES) > FRAME_OUT_W) ? $clog2(MAX_FRAMES) : FRAME_OUT_W;
	localparam int EW = PAGE_BITS + 2 + AW + FW;

	typedef struct packed {
		logic [PAGE_BITS-1:0] page;
		list_t                lst;
		logic [AW-1:0]        rank;
		logic [FW-1:0]        frame;
	} entry_t;

	typedef struct packed {
		op_kind_t      kind;
		logic [AW-1:0] idx;
		list_t         lst;
		logic [AW-1:0] rank;
		logic          kill;
		logic          setv;
	} op_t;

	localparam op_t OP_IDLE = '{kind: OP_NONE, idx: '0, lst: LIST_T1, rank: '0,
		kill: 1'b0, setv: 1'b0};

	state_t state_q, state_n;

	logic [CFG_W-1:0]     fc_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [AW:0]          sweep_q;
	logic                 pv_s1;
	logic [AW-1:0]        addr_s1;
	logic [CW-1:0]        cnt_q [4];
	logic [CW-1:0]        p_q;
	logic [NW-1:0]        nff_q;

	logic          found_q;
	logic [AW-1:0] e_idx_q;
	list_t         e_list_q;
	logic [AW-1:0] e_rank_q;
	logic [FW-1:0] e_frame_q;

	logic                 has_q [4];
	logic [AW-1:0]        lru_idx_q [4];
	logic [AW-1:0]        lru_rank_q [4];
	logic [PAGE_BITS-1:0] lru_page_q [4];
	logic [FW-1:0]        lru_frame_q [4];
	logic                 free_found_q;
	logic [AW-1:0]        free_idx_q;

	op_t           ops_q [4];
	logic          wf_en_q;
	logic          wp_en_q;
	logic [AW-1:0] wf_idx_q;
	logic [FW-1:0] wf_frame_q;

	outcome_t             res_outcome_q;
	logic                 res_evicted_q;
	logic [PAGE_BITS-1:0] res_vpage_q;
	logic [FW-1:0]        res_vframe_q;
	logic [FW-1:0]        res_frame_q;

	logic                   out_valid_q;
	logic [OUTC_W-1:0]      out_outcome_q;
	logic                   out_evicted_q;
	logic [PAGE_BITS-1:0]   out_vpage_q;
	logic [FRAME_OUT_W-1:0] out_vframe_q;
	logic [FRAME_OUT_W-1:0] out_frame_q;

	logic          rd_en;
	logic [EW-1:0] rd_data;
	logic          rd_valid;
	logic          wr_en;
	entry_t        se;
	entry_t        upd_e;
	logic          upd_v;
	logic          sweep_done;
	logic          div_start;
	logic          div_done;
	logic [CW-1:0] div_quo;
	logic          load_out;
	logic          accept;

	logic          resident_hit;
	logic          ghost_hit;
	logic [CW-1:0] cap;
	logic [CW-1:0] gd;
	logic [SW-1:0] psum;
	logic [CW-1:0] p_gh;
	logic [CW-1:0] gf_p;
	logic          gf_b2;
	logic          use_t1;
	list_t         src;
	list_t         gsrc;
	logic          gf_has_v;
	logic          gf_free;
	logic          nff_ok;

	op_t           ops_n [4];
	logic [CW-1:0] cnt_n [4];
	logic [CW-1:0] p_n;
	logic [NW-1:0] nff_n;
	outcome_t      d_outcome;
	logic          d_evicted;
	logic [PAGE_BITS-1:0] d_vpage;
	logic [FW-1:0] d_vframe;
	logic [FW-1:0] d_frame;
	logic          d_wf_en;
	logic          d_wp_en;
	logic [AW-1:0] d_wf_idx;
	logic          gf_call;
	logic          gf_ev;
	logic [1:0]    gb;
	logic          kill_en;
	logic [AW-1:0] kill_idx;
	logic          slot_ok;
	logic [AW-1:0] slot_idx;

	function automatic logic [CW-1:0] cnt_dec(input logic [CW-1:0] v);
		return (v != '0) ? v - CW'(1) : v;
	endfunction

	arcpr_dir #(
		.DEPTH(DEPTH),
		.W    (EW)
	) u_dir (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (sweep_q[AW-1:0]),
		.rd_data (rd_data),
		.rd_valid(rd_valid),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (upd_e),
		.wr_valid(upd_v)
	);

	arcpr_div #(
		.W(CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(e_list_q == LIST_B1 ? cnt_q[LIST_B2] : cnt_q[LIST_B1]),
		.divisor (e_list_q == LIST_B1 ? cnt_q[LIST_B1] : cnt_q[LIST_B2]),
		.done    (div_done),
		.quotient(div_quo)
	);

	assign se = entry_t'(rd_data);
	assign sweep_done = (sweep_q == (AW + 1)'(DEPTH)) && !pv_s1;
	assign resident_hit = found_q && (e_list_q == LIST_T1 || e_list_q == LIST_T2);
	assign ghost_hit = found_q && (e_list_q == LIST_B1 || e_list_q == LIST_B2);

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_n = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (sweep_done) state_n = ghost_hit ? ST_DIV : ST_DECIDE;
			end
			ST_DIV: begin
				if (div_done) state_n = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_n = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (sweep_done) state_n = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) state_n = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		accept = (state_q == ST_IDLE) && in_valid;
		rd_en = (state_q == ST_SEARCH || state_q == ST_UPDATE) &&
			(sweep_q < (AW + 1)'(DEPTH));
		wr_en = (state_q == ST_UPDATE) && pv_s1;
		div_start = (state_q == ST_SEARCH) && sweep_done && ghost_hit;
		load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	always_comb begin
		if (fc_q == '0) begin
			cap = CW'(1);
		end else if ({2'b00, fc_q} > 9'(MAX_FRAMES)) begin
			cap = CW'(MAX_FRAMES);
		end else begin
			cap = CW'(fc_q);
		end

		if (e_list_q == LIST_B1) begin
			gd = (cnt_q[LIST_B1] >= cnt_q[LIST_B2] || cnt_q[LIST_B1] == '0) ? CW'(1) : div_quo;
		end else begin
			gd = (cnt_q[LIST_B2] >= cnt_q[LIST_B1] || cnt_q[LIST_B2] == '0) ? CW'(1) : div_quo;
		end
		psum = SW'(p_q) + SW'(gd);
		if (e_list_q == LIST_B1) begin
			p_gh = (psum > SW'(cap)) ? cap : CW'(psum);
		end else begin
			p_gh = (p_q > gd) ? p_q - gd : '0;
		end

		gf_p = ghost_hit ? p_gh : p_q;
		gf_b2 = ghost_hit && (e_list_q == LIST_B2);
		use_t1 = (cnt_q[LIST_T1] != '0) &&
			(cnt_q[LIST_T1] > gf_p || (cnt_q[LIST_T1] == gf_p && gf_b2));
		if (has_q[use_t1 ? LIST_T1 : LIST_T2]) begin
			src = use_t1 ? LIST_T1 : LIST_T2;
		end else begin
			src = use_t1 ? LIST_T2 : LIST_T1;
		end
		gsrc = (src == LIST_T1) ? LIST_B1 : LIST_B2;
		gf_has_v = has_q[LIST_T1] || has_q[LIST_T2];
		nff_ok = nff_q < NW'(MAX_FRAMES);
		gf_free = (SW'(cnt_q[LIST_T1]) + SW'(cnt_q[LIST_T2]) < SW'(cap)) && nff_ok;
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			ops_n[k] = OP_IDLE;
			cnt_n[k] = cnt_q[k];
		end
		p_n = p_q;
		nff_n = nff_q;
		d_outcome = OUTC_MISS;
		d_evicted = 1'b0;
		d_vpage = '0;
		d_vframe = '0;
		d_frame = '0;
		d_wf_en = 1'b0;
		d_wp_en = 1'b0;
		d_wf_idx = '0;
		gf_call = 1'b0;
		gf_ev = 1'b0;
		gb = 2'd0;
		kill_en = 1'b0;
		kill_idx = '0;
		slot_ok = 1'b0;
		slot_idx = '0;

		if (resident_hit) begin
			d_outcome = (e_list_q == LIST_T1) ? OUTC_HIT_T1 : OUTC_HIT_T2;
			ops_n[0] = '{kind: OP_REMOVE, idx: e_idx_q, lst: e_list_q, rank: e_rank_q,
				kill: 1'b0, setv: 1'b0};
			ops_n[1] = '{kind: OP_PUSH, idx: e_idx_q, lst: LIST_T2, rank: '0,
				kill: 1'b0, setv: 1'b0};
			cnt_n[e_list_q] = cnt_dec(cnt_n[e_list_q]);
			cnt_n[LIST_T2] = cnt_n[LIST_T2] + CW'(1);
			d_frame = e_frame_q;
		end else if (ghost_hit) begin
			d_outcome = (e_list_q == LIST_B1) ? OUTC_GHOST_B1 : OUTC_GHOST_B2;
			p_n = p_gh;
			gf_call = 1'b1;
			gb = 2'd0;
		end else begin
			if (SW'(cnt_q[LIST_T1]) + SW'(cnt_q[LIST_B1]) >= SW'(cap)) begin
				if (cnt_q[LIST_T1] < cap) begin
					if (has_q[LIST_B1]) begin
						ops_n[0] = '{kind: OP_REMOVE, idx: lru_idx_q[LIST_B1], lst: LIST_B1,
							rank: lru_rank_q[LIST_B1], kill: 1'b1, setv: 1'b0};
						cnt_n[LIST_B1] = cnt_dec(cnt_n[LIST_B1]);
						kill_en = 1'b1;
						kill_idx = lru_idx_q[LIST_B1];
					end
					gf_call = 1'b1;
					gb = 2'd1;
				end else if (has_q[LIST_T1]) begin
					ops_n[0] = '{kind: OP_REMOVE, idx: lru_idx_q[LIST_T1], lst: LIST_T1,
						rank: lru_rank_q[LIST_T1], kill: 1'b1, setv: 1'b0};
					cnt_n[LIST_T1] = cnt_dec(cnt_n[LIST_T1]);
					kill_en = 1'b1;
					kill_idx = lru_idx_q[LIST_T1];
					d_evicted = 1'b1;
					d_vpage = lru_page_q[LIST_T1];
					d_vframe = lru_frame_q[LIST_T1];
					d_frame = lru_frame_q[LIST_T1];
				end else begin
					gf_call = 1'b1;
					gb = 2'd1;
				end
			end else begin
				if ((SW'(cnt_q[LIST_T1]) + SW'(cnt_q[LIST_T2]) + SW'(cnt_q[LIST_B1]) +
					SW'(cnt_q[LIST_B2]) >= (SW'(cap) << 1)) && has_q[LIST_B2]) begin
					ops_n[0] = '{kind: OP_REMOVE, idx: lru_idx_q[LIST_B2], lst: LIST_B2,
						rank: lru_rank_q[LIST_B2], kill: 1'b1, setv: 1'b0};
					cnt_n[LIST_B2] = cnt_dec(cnt_n[LIST_B2]);
					kill_en = 1'b1;
					kill_idx = lru_idx_q[LIST_B2];
				end
				gf_call = 1'b1;
				gb = 2'd1;
			end
		end

		if (gf_call) begin
			if (gf_free) begin
				d_frame = FW'(nff_q);
				nff_n = nff_q + NW'(1);
			end else if (gf_has_v) begin
				gf_ev = 1'b1;
				d_evicted = 1'b1;
				d_vpage = lru_page_q[src];
				d_vframe = lru_frame_q[src];
				d_frame = lru_frame_q[src];
				ops_n[gb] = '{kind: OP_REMOVE, idx: lru_idx_q[src], lst: src,
					rank: lru_rank_q[src], kill: 1'b0, setv: 1'b0};
				ops_n[gb + 2'd1] = '{kind: OP_PUSH, idx: lru_idx_q[src], lst: gsrc, rank: '0,
					kill: 1'b0, setv: 1'b0};
				cnt_n[src] = cnt_dec(cnt_n[src]);
				cnt_n[gsrc] = cnt_n[gsrc] + CW'(1);
			end else if (nff_ok) begin
				d_frame = FW'(nff_q);
				nff_n = nff_q + NW'(1);
			end
		end

		if (ghost_hit) begin
			ops_n[2] = '{kind: OP_REMOVE, idx: e_idx_q, lst: e_list_q,
				rank: e_rank_q + ((gf_ev && gsrc == e_list_q) ? AW'(1) : AW'(0)),
				kill: 1'b0, setv: 1'b0};
			ops_n[3] = '{kind: OP_PUSH, idx: e_idx_q, lst: LIST_T2, rank: '0,
				kill: 1'b0, setv: 1'b0};
			cnt_n[e_list_q] = cnt_dec(cnt_n[e_list_q]);
			cnt_n[LIST_T2] = cnt_n[LIST_T2] + CW'(1);
			d_wf_en = 1'b1;
			d_wf_idx = e_idx_q;
		end else if (!resident_hit) begin
			if (kill_en) begin
				slot_ok = 1'b1;
				slot_idx = (free_found_q && free_idx_q < kill_idx) ? free_idx_q : kill_idx;
			end else begin
				slot_ok = free_found_q;
				slot_idx = free_idx_q;
			end
			if (slot_ok) begin
				ops_n[3] = '{kind: OP_PUSH, idx: slot_idx, lst: LIST_T1, rank: '0,
					kill: 1'b0, setv: 1'b1};
				cnt_n[LIST_T1] = cnt_n[LIST_T1] + CW'(1);
				d_wf_en = 1'b1;
				d_wp_en = 1'b1;
				d_wf_idx = slot_idx;
			end
		end
	end

	always_comb begin
		upd_v = rd_valid;
		upd_e = se;
		for (int k = 0; k < 4; k++) begin
			case (ops_q[k].kind)
				OP_REMOVE: begin
					if (addr_s1 == ops_q[k].idx) begin
						if (ops_q[k].kill) upd_v = 1'b0;
					end else if (upd_v && upd_e.lst == ops_q[k].lst &&
						upd_e.rank > ops_q[k].rank) begin
						upd_e.rank = upd_e.rank - AW'(1);
					end
				end
				OP_PUSH: begin
					if (addr_s1 == ops_q[k].idx) begin
						if (ops_q[k].setv) upd_v = 1'b1;
						upd_e.lst = ops_q[k].lst;
						upd_e.rank = '0;
					end else if (upd_v && upd_e.lst == ops_q[k].lst) begin
						upd_e.rank = upd_e.rank + AW'(1);
					end
				end
				default: begin
				end
			endcase
		end
		if (wf_en_q && addr_s1 == wf_idx_q) begin
			upd_e.frame = wf_frame_q;
			if (wp_en_q) upd_e.page = page_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fc_q <= FRAME_COUNT_RST;
			sweep_q <= '0;
			pv_s1 <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				cnt_q[k] <= '0;
				has_q[k] <= 1'b0;
				ops_q[k] <= OP_IDLE;
			end
			p_q <= '0;
			nff_q <= '0;
			found_q <= 1'b0;
			free_found_q <= 1'b0;
			wf_en_q <= 1'b0;
			wp_en_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_valid) fc_q <= cfg_data;
			pv_s1 <= rd_en;
			if (rd_en) sweep_q <= sweep_q + (AW + 1)'(1);

			if (accept) begin
				sweep_q <= '0;
				found_q <= 1'b0;
				free_found_q <= 1'b0;
				for (int k = 0; k < 4; k++) begin
					has_q[k] <= 1'b0;
				end
			end

			if (state_q == ST_SEARCH && pv_s1) begin
				if (rd_valid) begin
					if (!found_q && se.page == page_q) begin
						found_q <= 1'b1;
					end
					for (int k = 0; k < 4; k++) begin
						if (se.lst == list_t'(2'(k)) &&
							(!has_q[k] || se.rank > lru_rank_q[k])) begin
							has_q[k] <= 1'b1;
						end
					end
				end else if (!free_found_q) begin
					free_found_q <= 1'b1;
				end
			end

			if (state_q == ST_DECIDE) begin
				sweep_q <= '0;
				for (int k = 0; k < 4; k++) begin
					cnt_q[k] <= cnt_n[k];
					ops_q[k] <= ops_n[k];
				end
				p_q <= p_n;
				nff_q <= nff_n;
				wf_en_q <= d_wf_en;
				wp_en_q <= d_wp_en;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) page_q <= page_id;
		if (rd_en) addr_s1 <= sweep_q[AW-1:0];

		if (state_q == ST_SEARCH && pv_s1) begin
			if (rd_valid) begin
				if (!found_q && se.page == page_q) begin
					e_idx_q <= addr_s1;
					e_list_q <= se.lst;
					e_rank_q <= se.rank;
					e_frame_q <= se.frame;
				end
				for (int k = 0; k < 4; k++) begin
					if (se.lst == list_t'(2'(k)) &&
						(!has_q[k] || se.rank > lru_rank_q[k])) begin
						lru_idx_q[k] <= addr_s1;
						lru_rank_q[k] <= se.rank;
						lru_page_q[k] <= se.page;
						lru_frame_q[k] <= se.frame;
					end
				end
			end else if (!free_found_q) begin
				free_idx_q <= addr_s1;
			end
		end

		if (state_q == ST_DECIDE) begin
			wf_idx_q <= d_wf_idx;
			wf_frame_q <= d_frame;
			res_outcome_q <= d_outcome;
			res_evicted_q <= d_evicted;
			res_vpage_q <= d_vpage;
			res_vframe_q <= d_vframe;
			res_frame_q <= d_frame;
		end

		if (load_out) begin
			out_outcome_q <= res_outcome_q;
			out_evicted_q <= res_evicted_q;
			out_vpage_q <= res_vpage_q;
			out_vframe_q <= res_vframe_q[FRAME_OUT_W-1:0];
			out_frame_q <= res_frame_q[FRAME_OUT_W-1:0];
		end
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign outcome = out_outcome_q;
	assign evicted = out_evicted_q;
	assign victim_page = out_vpage_q;
	assign victim_frame = out_vframe_q;
	assign page_frame = out_frame_q;

endmodule
